// File: hw/rtl/wnrs_pkg.sv
package wnrs_pkg;

    localparam int DEPTH      = 256;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int VALUE_BITS = 16;
    localparam int STAMP_BITS = 32;
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int TERM_BITS  = SQ_BITS + 8;
    localparam int DIST_BITS  = TERM_BITS + 3;
    localparam int REC_BITS   = STAMP_BITS + 10 * VALUE_BITS;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_MATCH  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [8:0] W_FOOD_IN   = 9'd9;
    localparam logic [8:0] W_WATER_IN  = 9'd9;
    localparam logic [8:0] W_TEMP_IN   = 9'd36;
    localparam logic [8:0] W_FOOD_LVL  = 9'd4;
    localparam logic [8:0] W_WATER_LVL = 9'd4;
    localparam logic [8:0] W_TEMP_LVL  = 9'd225;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        logic                load;
        logic                write;
        logic                scan_rd;
        logic                scan_first;
        logic                cmp_en;
        logic [IDX_BITS-1:0] addr;
    } t_cmd;

endpackage

// File: hw/rtl/weighted_nearest_record_search_core.sv
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_operation, i_stamp, i_*_in/ctrl/level, i_overall_value
// output  | o_valid | i_stall | o_status, o_match_*
// Store or query on an empty table: the result is presented directly, then held until taken.
// Query: the scan reads the record memory one entry per cycle into a 2-stage distance pipe,
// which drains through S_DRN1, S_DRN2 and S_FIN before the result is presented.
// Reset clears the entry count and control; memory contents are not cleared.
// One transaction at a time; o_stall is high until the result is taken.
module weighted_nearest_record_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic signed [31:0] i_stamp,
    input  logic signed [15:0] i_food_in, i_water_in, i_temp_in,
    input  logic signed [15:0] i_food_ctrl, i_water_ctrl, i_temp_ctrl,
    input  logic signed [15:0] i_food_level, i_water_level, i_temp_level,
    input  logic signed [15:0] i_overall_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_match_stamp,
    output logic signed [15:0] o_match_food_in, o_match_water_in, o_match_temp_in,
    output logic signed [15:0] o_match_food_ctrl, o_match_water_ctrl, o_match_temp_ctrl,
    output logic signed [15:0] o_match_food_level, o_match_water_level,
    output logic signed [15:0] o_match_temp_level,
    output logic signed [15:0] o_match_overall
);

    wnrs_pkg::t_cmd                  cmd;
    logic                            busy;
    logic [wnrs_pkg::REC_BITS-1:0]   best;
    logic [wnrs_pkg::REC_BITS-1:0]   res;

    assign o_stall = busy;

    wnrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_operation),
        .o_busy      (busy),
        .i_out_taken (!i_stall),
        .o_out_valid (o_valid),
        .o_status    (o_status),
        .o_cmd       (cmd)
    );

    wnrs_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_stamp (i_stamp),
        .i_vals  ({i_food_in, i_water_in, i_temp_in, i_food_ctrl, i_water_ctrl,
                   i_temp_ctrl, i_food_level, i_water_level, i_temp_level,
                   i_overall_value}),
        .o_best  (best)
    );

    assign res = (o_status == wnrs_pkg::ST_MATCH) ? best : '0;
    assign {o_match_stamp, o_match_food_in, o_match_water_in, o_match_temp_in,
            o_match_food_ctrl, o_match_water_ctrl, o_match_temp_ctrl,
            o_match_food_level, o_match_water_level, o_match_temp_level,
            o_match_overall} = res;

endmodule

// File: hw/rtl/wnrs_ctrl.sv
module wnrs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_op,
    output logic                          o_busy,
    input  logic                          i_out_taken,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output wnrs_pkg::t_cmd                o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DRN1 = 3'd2;
    localparam logic [2:0] S_DRN2 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [wnrs_pkg::CNT_BITS-1:0]   r_count;
    logic [wnrs_pkg::CNT_BITS-1:0]   r_idx;
    logic [1:0]                      r_status;
    logic                            take;

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;
    assign take        = i_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = take;
        o_cmd.write      = take && (i_op == wnrs_pkg::OP_STORE)
                           && (r_count != wnrs_pkg::CNT_BITS'(wnrs_pkg::DEPTH));
        o_cmd.addr       = (r_state == S_IDLE) ? r_count[wnrs_pkg::IDX_BITS-1:0]
                                               : r_idx[wnrs_pkg::IDX_BITS-1:0];
        o_cmd.scan_rd    = (r_state == S_SCAN);
        o_cmd.scan_first = (r_state == S_SCAN) && (r_idx == '0);
        o_cmd.cmp_en     = (r_state == S_SCAN);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (take) begin
                if (i_op == wnrs_pkg::OP_QUERY && r_count != '0) n_state = S_SCAN;
                else n_state = S_OUT;
            end
            S_SCAN: if (r_idx + 1'b1 == r_count) n_state = S_DRN1;
            S_DRN1: n_state = S_DRN2;
            S_DRN2: n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (i_out_taken) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_status <= wnrs_pkg::ST_STORED;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_idx <= '0;
                if (i_op == wnrs_pkg::OP_STORE) begin
                    if (o_cmd.write) begin
                        r_count  <= r_count + 1'b1;
                        r_status <= wnrs_pkg::ST_STORED;
                    end else begin
                        r_status <= wnrs_pkg::ST_FULL;
                    end
                end else begin
                    r_status <= (r_count == '0) ? wnrs_pkg::ST_EMPTY : wnrs_pkg::ST_MATCH;
                end
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wnrs_pkg::CNT_BITS'(wnrs_pkg::DEPTH))
        else $error("count overflow");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_count))
        else $error("scan beyond count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_taken) |=> o_out_valid)
        else $error("result dropped");

endmodule

// File: hw/rtl/wnrs_dp.sv
module wnrs_dp (
    input  logic                                  i_clk,
    input  wnrs_pkg::t_cmd                        i_cmd,
    input  logic [wnrs_pkg::STAMP_BITS-1:0]       i_stamp,
    input  logic [10*wnrs_pkg::VALUE_BITS-1:0]    i_vals,
    output logic [wnrs_pkg::REC_BITS-1:0]         o_best
);

    localparam int VB = wnrs_pkg::VALUE_BITS;

    logic [wnrs_pkg::REC_BITS-1:0]   r_mem [wnrs_pkg::DEPTH];
    logic [wnrs_pkg::REC_BITS-1:0]   r_q;
    logic [wnrs_pkg::STAMP_BITS-1:0] r_qstamp;
    logic [10*VB-1:0]                r_qvals;
    logic                            r_v1, r_v2, r_first1, r_first2;
    logic [wnrs_pkg::REC_BITS-1:0]   r_rec2;
    logic [wnrs_pkg::TERM_BITS-1:0]  r_term [6];
    logic [wnrs_pkg::DIST_BITS-1:0]  r_best_d;
    logic [wnrs_pkg::REC_BITS-1:0]   r_best;
    logic [wnrs_pkg::DIST_BITS-1:0]  sum_d;
    logic [8:0]                      wt [6];
    logic signed [VB-1:0]            ev [6];
    logic signed [VB-1:0]            qv [6];

    always_comb begin
        wt[0] = wnrs_pkg::W_FOOD_IN;  wt[1] = wnrs_pkg::W_WATER_IN;
        wt[2] = wnrs_pkg::W_TEMP_IN;  wt[3] = wnrs_pkg::W_FOOD_LVL;
        wt[4] = wnrs_pkg::W_WATER_LVL; wt[5] = wnrs_pkg::W_TEMP_LVL;
        for (int k = 0; k < 3; k++) begin
            ev[k]   = r_q[(9-k)*VB +: VB];
            ev[k+3] = r_q[(3-k)*VB +: VB];
            qv[k]   = r_qvals[(9-k)*VB +: VB];
            qv[k+3] = r_qvals[(3-k)*VB +: VB];
        end
        sum_d = '0;
        for (int k = 0; k < 6; k++) sum_d = sum_d + wnrs_pkg::DIST_BITS'(r_term[k]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) r_mem[i_cmd.addr] <= {i_stamp, i_vals};
        if (i_cmd.scan_rd) r_q <= r_mem[i_cmd.addr];
        if (i_cmd.load) begin
            r_qstamp <= i_stamp;
            r_qvals  <= i_vals;
            r_best   <= '0;
        end
        r_v1     <= i_cmd.cmp_en;
        r_first1 <= i_cmd.scan_first;
        r_v2     <= r_v1;
        r_first2 <= r_first1;
        r_rec2   <= r_q;
        for (int k = 0; k < 6; k++) begin
            logic signed [VB:0]             d;
            logic [VB:0]                    a;
            logic [wnrs_pkg::SQ_BITS-1:0]   sq;
            d = {ev[k][VB-1], ev[k]} - {qv[k][VB-1], qv[k]};
            a = d[VB] ? (VB+1)'(-d) : d;
            sq = wnrs_pkg::SQ_BITS'(a) * wnrs_pkg::SQ_BITS'(a);
            r_term[k] <= wnrs_pkg::TERM_BITS'(sq) * wnrs_pkg::TERM_BITS'(wt[k]);
        end
        if (r_v2) begin
            if (r_first2 || (sum_d < r_best_d &&
                r_rec2[wnrs_pkg::REC_BITS-1 -: wnrs_pkg::STAMP_BITS] != r_qstamp)) begin
                r_best_d <= sum_d;
                r_best   <= r_rec2;
            end
        end
    end

    assign o_best = r_best;

endmodule

// File: tb/sv/weighted_nearest_record_search_checker.sv
module weighted_nearest_record_search_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic              i_operation,
    input  logic signed [31:0] i_stamp,
    input  logic signed [15:0] i_food_in, i_water_in, i_temp_in,
    input  logic signed [15:0] i_food_ctrl, i_water_ctrl, i_temp_ctrl,
    input  logic signed [15:0] i_food_level, i_water_level, i_temp_level,
    input  logic signed [15:0] i_overall_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [1:0]        i_status,
    input  logic signed [31:0] i_match_stamp,
    input  logic signed [15:0] i_match_food_in, i_match_water_in, i_match_temp_in,
    input  logic signed [15:0] i_match_food_ctrl, i_match_water_ctrl, i_match_temp_ctrl,
    input  logic signed [15:0] i_match_food_level, i_match_water_level,
    input  logic signed [15:0] i_match_temp_level,
    input  logic signed [15:0] i_match_overall,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [31:0]         stamp;
        wnrs_pkg::t_val [9:0]       vals;
    } t_record_result;

    logic [31:0]          rec_stamp [wnrs_pkg::DEPTH];
    wnrs_pkg::t_val [9:0] rec_vals [wnrs_pkg::DEPTH];
    int                   rec_count;
    t_record_result       pending_results [$];

    assign o_pending = pending_results.size();

    function automatic longint unsigned weighted_term(wnrs_pkg::t_val a, wnrs_pkg::t_val b,
                                                      int w);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d * d * w);
    endfunction

    function automatic longint unsigned record_distance(int e, wnrs_pkg::t_val [9:0] q);
        return weighted_term(rec_vals[e][0], q[0], 9) + weighted_term(rec_vals[e][1], q[1], 9)
             + weighted_term(rec_vals[e][2], q[2], 36) + weighted_term(rec_vals[e][6], q[6], 4)
             + weighted_term(rec_vals[e][7], q[7], 4)
             + weighted_term(rec_vals[e][8], q[8], 225);
    endfunction

    function automatic t_record_result predict_nearest(logic op, logic [31:0] st,
                                                       wnrs_pkg::t_val [9:0] q);
        t_record_result r;
        int best;
        longint unsigned best_d, d;
        r = '0;
        if (op == wnrs_pkg::OP_STORE) begin
            if (rec_count >= wnrs_pkg::DEPTH) begin
                r.status = wnrs_pkg::ST_FULL;
            end else begin
                rec_stamp[rec_count] = st;
                rec_vals[rec_count] = q;
                rec_count++;
                r.status = wnrs_pkg::ST_STORED;
            end
        end else if (rec_count == 0) begin
            r.status = wnrs_pkg::ST_EMPTY;
        end else begin
            best = 0;
            best_d = record_distance(0, q);
            for (int e = 1; e < rec_count; e++) begin
                d = record_distance(e, q);
                if (d < best_d && rec_stamp[e] != st) begin
                    best = e;
                    best_d = d;
                end
            end
            r.status = wnrs_pkg::ST_MATCH;
            r.stamp = rec_stamp[best];
            r.vals = rec_vals[best];
        end
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_record_result e;
        wnrs_pkg::t_val [9:0] q;
        if (!i_rst_n) begin
            rec_count = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("status", e.status, i_status);
                    check_field("match_stamp", e.stamp, i_match_stamp);
                    check_field("match_food_in", e.vals[0], i_match_food_in);
                    check_field("match_water_in", e.vals[1], i_match_water_in);
                    check_field("match_temp_in", e.vals[2], i_match_temp_in);
                    check_field("match_food_ctrl", e.vals[3], i_match_food_ctrl);
                    check_field("match_water_ctrl", e.vals[4], i_match_water_ctrl);
                    check_field("match_temp_ctrl", e.vals[5], i_match_temp_ctrl);
                    check_field("match_food_level", e.vals[6], i_match_food_level);
                    check_field("match_water_level", e.vals[7], i_match_water_level);
                    check_field("match_temp_level", e.vals[8], i_match_temp_level);
                    check_field("match_overall", e.vals[9], i_match_overall);
                end
            end
            if (i_valid && !i_in_stall) begin
                q = {i_overall_value, i_temp_level, i_water_level, i_food_level,
                     i_temp_ctrl, i_water_ctrl, i_food_ctrl,
                     i_temp_in, i_water_in, i_food_in};
                pending_results.push_back(predict_nearest(i_operation, i_stamp, q));
            end
        end
    end

endmodule

// File: tb/sv/weighted_nearest_record_search_core_test.sv
module weighted_nearest_record_search_core_test;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic i_operation = 0;
    logic signed [31:0] i_stamp = 0;
    logic signed [15:0] i_food_in = 0, i_water_in = 0, i_temp_in = 0;
    logic signed [15:0] i_food_ctrl = 0, i_water_ctrl = 0, i_temp_ctrl = 0;
    logic signed [15:0] i_food_level = 0, i_water_level = 0, i_temp_level = 0;
    logic signed [15:0] i_overall_value = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [1:0] o_status;
    logic signed [31:0] o_match_stamp;
    logic signed [15:0] o_match_food_in, o_match_water_in, o_match_temp_in;
    logic signed [15:0] o_match_food_ctrl, o_match_water_ctrl, o_match_temp_ctrl;
    logic signed [15:0] o_match_food_level, o_match_water_level, o_match_temp_level;
    logic signed [15:0] o_match_overall;
    int fail_count, pending;
    int idle_cycles = 0;
    logic hold_off = 0;
    logic [31:0] last_stamp = 0;

    always #5 i_clk = ~i_clk;

    weighted_nearest_record_search_core dut (.*);

    weighted_nearest_record_search_checker checker_u (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_operation, .i_stamp,
        .i_food_in, .i_water_in, .i_temp_in, .i_food_ctrl, .i_water_ctrl, .i_temp_ctrl,
        .i_food_level, .i_water_level, .i_temp_level, .i_overall_value,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_status(o_status),
        .i_match_stamp(o_match_stamp), .i_match_food_in(o_match_food_in),
        .i_match_water_in(o_match_water_in), .i_match_temp_in(o_match_temp_in),
        .i_match_food_ctrl(o_match_food_ctrl), .i_match_water_ctrl(o_match_water_ctrl),
        .i_match_temp_ctrl(o_match_temp_ctrl), .i_match_food_level(o_match_food_level),
        .i_match_water_level(o_match_water_level),
        .i_match_temp_level(o_match_temp_level), .i_match_overall(o_match_overall),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1;
        else case ($urandom_range(0, 3))
            0: i_stall <= ($urandom_range(0, 1) == 1);
            1: i_stall <= ($urandom_range(0, 7) == 0);
            default: i_stall <= 0;
        endcase
    end

    initial begin
        repeat (100000) @(posedge i_clk);
        hold_off = 1;
        repeat (2000) @(posedge i_clk);
        hold_off = 0;
    end

    function automatic logic signed [15:0] pick_value(int mode);
        case (mode)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'(signed'($urandom_range(0, 64) - 32));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic op, logic [31:0] st, int mode);
        i_operation <= op;
        i_stamp <= st;
        i_food_in <= pick_value(mode);
        i_water_in <= pick_value(mode);
        i_temp_in <= pick_value(mode);
        i_food_ctrl <= pick_value(mode);
        i_water_ctrl <= pick_value(mode);
        i_temp_ctrl <= pick_value(mode);
        i_food_level <= pick_value(mode);
        i_water_level <= pick_value(mode);
        i_temp_level <= pick_value(mode);
        i_overall_value <= pick_value(mode);
        i_valid <= 1;
        if (op == wnrs_pkg::OP_STORE) last_stamp = st;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] st;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_item(wnrs_pkg::OP_QUERY, 0, 2);
        send_item(wnrs_pkg::OP_STORE, 32'h7fffffff, 0);
        send_item(wnrs_pkg::OP_QUERY, 32'h7fffffff, 0);
        send_item(wnrs_pkg::OP_STORE, 32'h80000000, 1);
        send_item(wnrs_pkg::OP_QUERY, 32'h80000000, 1);
        send_item(wnrs_pkg::OP_QUERY, 32'h7fffffff, 1);
        send_item(wnrs_pkg::OP_STORE, 5, 2);
        send_item(wnrs_pkg::OP_STORE, 6, 2);
        send_item(wnrs_pkg::OP_QUERY, 7, 2);
        send_item(wnrs_pkg::OP_QUERY, 5, 2);
        send_item(wnrs_pkg::OP_STORE, 0, 4);
        send_item(wnrs_pkg::OP_QUERY, 0, 4);
        for (int n = 0; n < 1750; n++) begin
            if (n == 1000) begin
                i_valid <= 0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            st = ($urandom_range(0, 3) == 0) ? last_stamp : $urandom;
            send_item(($urandom_range(0, 2) == 0) ? wnrs_pkg::OP_STORE : wnrs_pkg::OP_QUERY,
                      st, $urandom_range(0, 9) < 6 ? 3 : $urandom_range(0, 4));
            if ($urandom_range(0, 5) == 0) drop_valid();
        end
        i_valid <= 0;
        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
